// ===== design/gpio_change_trace_logger_unit_macros.svh =====
// ----------------------------------------------------------------------------
// gpio change trace logger - assertion macros
// shared property forms for the checker, clocked on i_clk, off in reset
// ----------------------------------------------------------------------------
`ifndef GPIO_CHANGE_TRACE_LOGGER_UNIT_MACROS_SVH
`define GPIO_CHANGE_TRACE_LOGGER_UNIT_MACROS_SVH

// same-cycle implication
`define GCTL_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define GCTL_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/gctl_pkg.sv =====
// ----------------------------------------------------------------------------
// gctl_pkg
// types, codes and constants shared by the gpio change trace logger
// ----------------------------------------------------------------------------
package gctl_pkg;

    localparam int LVL_W      = 16;
    localparam int CNT_W      = 16;
    localparam int CFG_COUNT  = 5;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam int DEF_TX_RING_DEPTH    = 32;
    localparam int DEF_EVENT_RING_DEPTH = 64;
    localparam int DEF_PORT_COUNT       = 5;
    localparam int DEF_PINS_PER_PORT    = 16;

    localparam logic [1:0] OP_SAMPLE = 2'd0;
    localparam logic [1:0] OP_TX     = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;

    localparam logic [1:0] REC_TX    = 2'd0;
    localparam logic [1:0] REC_LEVEL = 2'd1;
    localparam logic [1:0] REC_CFG   = 2'd2;
    localparam logic [1:0] REC_COUNT = 2'd3;

    typedef enum logic [1:0] {
        JOB_SAMPLE,
        JOB_TX,
        JOB_READ
    } t_job_kind;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_FIRST,
        BK_SECOND
    } t_back_state;

    typedef struct packed {
        logic [1:0]  operation;
        logic        tick_start;
        logic [2:0]  port;
        logic [3:0]  pin;
        logic [15:0] out_level;
        logic [31:0] config_low;
        logic [31:0] config_high;
        logic [39:0] frame_first;
        logic [39:0] frame_second;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  rec_kind;
        logic [5:0]  rec_slot;
        logic [31:0] rec_stamp;
        logic [2:0]  rec_port;
        logic [15:0] rec_new_level;
        logic [15:0] rec_old_level;
        logic [31:0] rec_cfg_low;
        logic [31:0] rec_cfg_high;
        logic [39:0] rec_frame_first;
        logic [39:0] rec_frame_second;
        logic [15:0] toggle_count;
        logic        last_of_run;
    } t_out_item;

    typedef struct packed {
        t_job_kind   kind;
        logic [31:0] stamp;
        logic [2:0]  port;
        logic [3:0]  pin;
        logic        has_lvl;
        logic        has_cfg;
        logic [5:0]  slot_a;
        logic [5:0]  slot_b;
        logic [15:0] new_level;
        logic [15:0] old_level;
        logic [31:0] cfg_low;
        logic [31:0] cfg_high;
        logic [39:0] frame_first;
        logic [39:0] frame_second;
    } t_job;

endpackage

// ===== design/gctl_front.sv =====
// ----------------------------------------------------------------------------
// gctl_front
// accepts items, keeps shadows, masks and ring slots, emits record jobs
// ----------------------------------------------------------------------------
module gctl_front import gctl_pkg::*; #(
    parameter int TX_RING_DEPTH    = DEF_TX_RING_DEPTH,
    parameter int EVENT_RING_DEPTH = DEF_EVENT_RING_DEPTH,
    parameter int PORT_COUNT       = DEF_PORT_COUNT
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    input  t_in_item              i_in_item,
    input  logic                  i_q_full,
    output logic                  o_push,
    output t_job                  o_job
);

    localparam int TX_SW   = (TX_RING_DEPTH > 1) ? $clog2(TX_RING_DEPTH) : 1;
    localparam int EV_SW   = (EVENT_RING_DEPTH > 1) ? $clog2(EVENT_RING_DEPTH) : 1;
    localparam int PORT_AW = (PORT_COUNT > 1) ? $clog2(PORT_COUNT) : 1;

    logic [CFG_DATA_W-1:0] r_mask [CFG_COUNT];
    logic [31:0]           r_tick;
    logic [31:0]           r_tx_total;
    logic [TX_SW-1:0]      r_tx_slot;
    logic [31:0]           r_ev_total;
    logic [EV_SW-1:0]      r_ev_slot;
    logic [LVL_W-1:0]      r_lvl_shadow [PORT_COUNT];
    logic [63:0]           r_cfg_shadow [PORT_COUNT];
    logic [PORT_COUNT-1:0] r_primed;

    logic [31:0]      n_tick;
    logic [31:0]      n_ev_total;
    logic [EV_SW-1:0] n_ev_slot;
    logic [31:0]      ev_total_1;
    logic [EV_SW-1:0] ev_slot_1;
    logic [31:0]      ev_total_2;
    logic [EV_SW-1:0] ev_slot_2;
    logic [TX_SW-1:0] tx_slot_nxt;

    logic               acc;
    logic               is_sample;
    logic               is_tx;
    logic               is_read;
    logic               port_ok;
    logic [PORT_AW-1:0] pidx;
    logic               primed;
    logic [LVL_W-1:0]   keep;
    logic [LVL_W-1:0]   new_lvl;
    logic [LVL_W-1:0]   old_lvl;
    logic [63:0]        cfg_word;
    logic               has_lvl;
    logic               has_cfg;

    function automatic logic [EV_SW-1:0] ev_step(input logic [31:0] total,
                                                 input logic [EV_SW-1:0] slot);
        logic [EV_SW-1:0] res;
        if (total == 32'hFFFF_FFFF) begin
            res = '0;
        end else if (slot == EV_SW'(EVENT_RING_DEPTH - 1)) begin
            res = '0;
        end else begin
            res = slot + EV_SW'(1);
        end
        return res;
    endfunction

    assign acc       = i_in_valid && !i_q_full;
    assign is_sample = (i_in_item.operation == OP_SAMPLE);
    assign is_tx     = (i_in_item.operation == OP_TX);
    assign is_read   = (i_in_item.operation == OP_READ);
    assign port_ok   = ({1'b0, i_in_item.port} < 4'(PORT_COUNT));
    assign pidx      = i_in_item.port[PORT_AW-1:0];
    assign primed    = r_primed[pidx];
    assign cfg_word  = {i_in_item.config_high, i_in_item.config_low};

    always_comb begin
        keep = '1;
        for (int i = 0; i < CFG_COUNT; i++) begin
            if (i_in_item.port == 3'(i)) begin
                keep = ~r_mask[i];
            end
        end
    end

    assign new_lvl = i_in_item.out_level & keep;
    assign old_lvl = r_lvl_shadow[pidx] & keep;
    assign has_lvl = is_sample && port_ok && primed && (new_lvl != old_lvl);
    assign has_cfg = is_sample && port_ok && primed && (cfg_word != r_cfg_shadow[pidx]);

    assign n_tick = r_tick + 32'(is_sample && i_in_item.tick_start);

    // event ring slots, one step per record
    assign ev_total_1 = r_ev_total + 32'd1;
    assign ev_slot_1  = ev_step(r_ev_total, r_ev_slot);
    assign ev_total_2 = ev_total_1 + 32'd1;
    assign ev_slot_2  = ev_step(ev_total_1, ev_slot_1);

    always_comb begin
        n_ev_total = r_ev_total;
        n_ev_slot  = r_ev_slot;
        if (has_lvl && has_cfg) begin
            n_ev_total = ev_total_2;
            n_ev_slot  = ev_slot_2;
        end else if (has_lvl || has_cfg) begin
            n_ev_total = ev_total_1;
            n_ev_slot  = ev_slot_1;
        end
    end

    always_comb begin
        if (r_tx_total == 32'hFFFF_FFFF) begin
            tx_slot_nxt = '0;
        end else if (r_tx_slot == TX_SW'(TX_RING_DEPTH - 1)) begin
            tx_slot_nxt = '0;
        end else begin
            tx_slot_nxt = r_tx_slot + TX_SW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CFG_COUNT; i++) begin
                r_mask[i] <= '0;
            end
            r_tick     <= '0;
            r_tx_total <= '0;
            r_tx_slot  <= '0;
            r_ev_total <= '0;
            r_ev_slot  <= '0;
            r_primed   <= '0;
        end else begin
            for (int i = 0; i < CFG_COUNT; i++) begin
                if (i_cfg_we && (i_cfg_idx == CFG_IDX_W'(i))) begin
                    r_mask[i] <= i_cfg_data;
                end
            end
            if (acc) begin
                r_tick     <= n_tick;
                r_ev_total <= n_ev_total;
                r_ev_slot  <= n_ev_slot;
                if (is_tx) begin
                    r_tx_total <= r_tx_total + 32'd1;
                    r_tx_slot  <= tx_slot_nxt;
                end
                if (is_sample && port_ok) begin
                    r_primed[pidx] <= 1'b1;
                end
            end
        end
    end

    // shadows, primed flag guards them
    always_ff @(posedge i_clk) begin
        if (acc && is_sample && port_ok) begin
            if (!primed) begin
                r_lvl_shadow[pidx] <= i_in_item.out_level;
                r_cfg_shadow[pidx] <= cfg_word;
            end else begin
                if (has_lvl) begin
                    r_lvl_shadow[pidx] <= new_lvl;
                end
                if (has_cfg) begin
                    r_cfg_shadow[pidx] <= cfg_word;
                end
            end
        end
    end

    assign o_push = acc && (has_lvl || has_cfg || is_tx || is_read);

    always_comb begin
        o_job              = '0;
        o_job.kind         = is_tx ? JOB_TX : (is_read ? JOB_READ : JOB_SAMPLE);
        o_job.stamp        = n_tick;
        o_job.port         = i_in_item.port;
        o_job.pin          = i_in_item.pin;
        o_job.has_lvl      = has_lvl;
        o_job.has_cfg      = has_cfg;
        o_job.slot_a       = is_tx ? 6'(r_tx_slot) : 6'(r_ev_slot);
        o_job.slot_b       = has_lvl ? 6'(ev_slot_1) : 6'(r_ev_slot);
        o_job.new_level    = new_lvl;
        o_job.old_level    = old_lvl;
        o_job.cfg_low      = i_in_item.config_low;
        o_job.cfg_high     = i_in_item.config_high;
        o_job.frame_first  = i_in_item.frame_first;
        o_job.frame_second = i_in_item.frame_second;
    end

endmodule

// ===== design/gctl_queue.sv =====
// ----------------------------------------------------------------------------
// gctl_queue
// two-entry job queue between front and back
// ----------------------------------------------------------------------------
module gctl_queue import gctl_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output logic o_full,
    output logic o_valid,
    output t_job o_head
);

    t_job       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_head  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

endmodule

// ===== design/gctl_back.sv =====
// ----------------------------------------------------------------------------
// gctl_back
// toggle counter memory, record assembly and output register
// ----------------------------------------------------------------------------
module gctl_back import gctl_pkg::*; #(
    parameter int PORT_COUNT    = DEF_PORT_COUNT,
    parameter int PINS_PER_PORT = DEF_PINS_PER_PORT
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_q_valid,
    input  t_job      i_q_head,
    output logic      o_pop,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    localparam int PORT_AW = (PORT_COUNT > 1) ? $clog2(PORT_COUNT) : 1;
    localparam int ROW_W   = CNT_W * PINS_PER_PORT;

    logic [ROW_W-1:0]      r_ram [PORT_COUNT];
    logic [PORT_COUNT-1:0] r_row_vld;
    logic [ROW_W-1:0]      r_row;
    t_job                  r_job;
    t_back_state           r_state;
    t_back_state           n_state;
    logic                  r_out_vld;
    t_out_item             r_out;

    logic                          out_free;
    logic                          load;
    logic                          sel_second;
    logic                          done;
    logic                          wr_en;
    logic                          two_recs;
    logic [PORT_AW-1:0]            wa;
    logic [PORT_AW-1:0]            ra;
    logic                          rd_ok;
    logic [LVL_W-1:0]              diff;
    logic [PINS_PER_PORT+LVL_W-1:0] diff_ext;
    logic [ROW_W-1:0]              inc_row;
    logic [CNT_W-1:0]              cnt;
    logic                          pin_ok;
    t_out_item                     rec_first;
    t_out_item                     rec_second;

    assign out_free = !r_out_vld || !i_out_stall;
    assign two_recs = (r_job.kind == JOB_SAMPLE) && r_job.has_lvl && r_job.has_cfg;
    assign wa       = r_job.port[PORT_AW-1:0];
    assign ra       = i_q_head.port[PORT_AW-1:0];
    assign rd_ok    = ({1'b0, i_q_head.port} < 4'(PORT_COUNT));

    // saturating increment of every changed pin
    assign diff     = r_job.new_level ^ r_job.old_level;
    assign diff_ext = (PINS_PER_PORT + LVL_W)'(diff);

    always_comb begin
        inc_row = r_row;
        for (int b = 0; b < PINS_PER_PORT; b++) begin
            cnt = r_row[b*CNT_W +: CNT_W];
            if (diff_ext[b] && (cnt != '1)) begin
                inc_row[b*CNT_W +: CNT_W] = cnt + CNT_W'(1);
            end
        end
    end

    assign pin_ok = ({1'b0, r_job.port} < 4'(PORT_COUNT))
                 && ({2'b00, r_job.pin} < 6'(PINS_PER_PORT));

    always_comb begin
        rec_first  = '0;
        rec_second = '0;

        rec_second.rec_kind     = REC_CFG;
        rec_second.rec_slot     = r_job.slot_b;
        rec_second.rec_stamp    = r_job.stamp;
        rec_second.rec_port     = r_job.port;
        rec_second.rec_cfg_low  = r_job.cfg_low;
        rec_second.rec_cfg_high = r_job.cfg_high;
        rec_second.last_of_run  = 1'b1;

        unique case (r_job.kind)
            JOB_TX: begin
                rec_first.rec_kind         = REC_TX;
                rec_first.rec_slot         = r_job.slot_a;
                rec_first.rec_stamp        = r_job.stamp;
                rec_first.rec_frame_first  = r_job.frame_first;
                rec_first.rec_frame_second = r_job.frame_second;
                rec_first.last_of_run      = 1'b1;
            end
            JOB_READ: begin
                rec_first.rec_kind    = REC_COUNT;
                rec_first.rec_stamp   = r_job.stamp;
                rec_first.rec_port    = r_job.port;
                rec_first.last_of_run = 1'b1;
                if (pin_ok) begin
                    rec_first.toggle_count = r_row[r_job.pin*CNT_W +: CNT_W];
                end
            end
            JOB_SAMPLE: begin
                if (r_job.has_lvl) begin
                    rec_first.rec_kind      = REC_LEVEL;
                    rec_first.rec_slot      = r_job.slot_a;
                    rec_first.rec_stamp     = r_job.stamp;
                    rec_first.rec_port      = r_job.port;
                    rec_first.rec_new_level = r_job.new_level;
                    rec_first.rec_old_level = r_job.old_level;
                    rec_first.last_of_run   = !r_job.has_cfg;
                end else begin
                    rec_first = rec_second;
                    rec_first.rec_slot = r_job.slot_a;
                end
            end
            default: begin
                rec_first = '0;
            end
        endcase
    end

    always_comb begin
        n_state    = r_state;
        load       = 1'b0;
        sel_second = 1'b0;
        done       = 1'b0;
        wr_en      = 1'b0;
        unique case (r_state)
            BK_IDLE: begin
                done = 1'b1;
            end
            BK_FIRST: begin
                if (out_free) begin
                    load  = 1'b1;
                    wr_en = (r_job.kind == JOB_SAMPLE) && r_job.has_lvl;
                    if (two_recs) begin
                        n_state = BK_SECOND;
                    end else begin
                        done = 1'b1;
                    end
                end
            end
            BK_SECOND: begin
                if (out_free) begin
                    load       = 1'b1;
                    sel_second = 1'b1;
                    done       = 1'b1;
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
        o_pop = done && i_q_valid;
        if (done) begin
            n_state = i_q_valid ? BK_FIRST : BK_IDLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= BK_IDLE;
            r_out_vld <= 1'b0;
            r_row_vld <= '0;
        end else begin
            r_state <= n_state;
            if (load) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
            if (wr_en) begin
                r_row_vld[wa] <= 1'b1;
            end
        end
    end

    // counter rows, read with forwarding of a same-cycle write
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_ram[wa] <= inc_row;
        end
        if (o_pop) begin
            r_job <= i_q_head;
            if (!rd_ok) begin
                r_row <= '0;
            end else if (wr_en && (wa == ra)) begin
                r_row <= inc_row;
            end else if (r_row_vld[ra]) begin
                r_row <= r_ram[ra];
            end else begin
                r_row <= '0;
            end
        end
        if (load) begin
            r_out <= sel_second ? rec_second : rec_first;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out;

endmodule

// ===== design/gpio_change_trace_logger_unit.sv =====
// ----------------------------------------------------------------------------
// gpio_change_trace_logger_unit
// trace logger for gpio ports: level and config change records, tx frame
// records and toggle counter readback
//
//   channel   signals                                    direction
//   in        i_in_valid, o_in_stall, i_in_item          item in
//   out       o_out_valid, i_out_stall, o_out_item       record out
//   cfg       i_cfg_we, i_cfg_idx, i_cfg_data            ignore masks in
//
// front takes one item a cycle while the two-entry job queue has room
// back retires a one-record item per cycle while the single output register is free
// and a two-record item record by record; each item passes queue, job register
// and output register; counter rows read at pop, same-row write forwarded
// reset is synchronous; counter rows cleared by per-row valid bits, no sweep
// a stalled output holds its record and backs up into queue and front
// ----------------------------------------------------------------------------
module gpio_change_trace_logger_unit import gctl_pkg::*; #(
    parameter int TX_RING_DEPTH    = DEF_TX_RING_DEPTH,
    parameter int EVENT_RING_DEPTH = DEF_EVENT_RING_DEPTH,
    parameter int PORT_COUNT       = DEF_PORT_COUNT,
    parameter int PINS_PER_PORT    = DEF_PINS_PER_PORT
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_item              i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_item             o_out_item
);

    logic q_full;
    logic q_valid;
    logic push;
    logic pop;
    t_job job;
    t_job head;

    assign o_in_stall = q_full;

    gctl_front #(
        .TX_RING_DEPTH    (TX_RING_DEPTH),
        .EVENT_RING_DEPTH (EVENT_RING_DEPTH),
        .PORT_COUNT       (PORT_COUNT)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in_valid (i_in_valid),
        .i_in_item  (i_in_item),
        .i_q_full   (q_full),
        .o_push     (push),
        .o_job      (job)
    );

    gctl_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_head  (head)
    );

    gctl_back #(
        .PORT_COUNT    (PORT_COUNT),
        .PINS_PER_PORT (PINS_PER_PORT)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_head    (head),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule

// ===== design/gctl_checker.sv =====
// ----------------------------------------------------------------------------
// gctl_checker
// port-level checks on the record stream of the trace logger
// ----------------------------------------------------------------------------
`include "gpio_change_trace_logger_unit_macros.svh"

module gctl_checker import gctl_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_out_valid,
    input logic      i_out_stall,
    input t_out_item i_out_item
);

    logic held;
    logic rec_level;
    logic rec_tx;
    logic rec_lone;
    logic level_moved;
    logic tx_clean;

    assign held        = i_out_valid && i_out_stall;
    assign rec_level   = i_out_valid && (i_out_item.rec_kind == REC_LEVEL);
    assign rec_tx      = i_out_valid && (i_out_item.rec_kind == REC_TX);
    assign rec_lone    = i_out_valid && (i_out_item.rec_kind != REC_LEVEL);
    assign level_moved = (i_out_item.rec_new_level != i_out_item.rec_old_level);
    assign tx_clean    = (i_out_item.rec_port == 3'd0) && (i_out_item.toggle_count == 16'd0)
                      && (i_out_item.rec_cfg_low == 32'd0);

    `GCTL_ASSERT_NXT(a_out_hold, held, i_out_valid && $stable(i_out_item), "stalled record changed")

    `GCTL_ASSERT_IMP(a_level_differs, rec_level, level_moved, "level record without change")

    `GCTL_ASSERT_IMP(a_single_last, rec_lone, i_out_item.last_of_run, "lone record not last")

    `GCTL_ASSERT_IMP(a_tx_clean, rec_tx, tx_clean, "tx record carries foreign fields")

endmodule

bind gpio_change_trace_logger_unit gctl_checker u_gctl_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .i_out_item  (o_out_item)
);
